// ===== src/bounded_stack_with_delete_assert.svh =====
// Assertion macros for the bounded stack with delete.
`ifndef BOUNDED_STACK_WITH_DELETE_ASSERT_SVH
`define BOUNDED_STACK_WITH_DELETE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BSTK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BSTK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bstk_pkg.sv =====
// Types and constants shared by the bounded stack with delete.
package bstk_pkg;

  localparam int unsigned DefaultDepth = 8;
  localparam int unsigned DataW        = 32;
  localparam int unsigned DepthNowW    = 4;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_DELETE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOTFOUND  = 2'd3
  } status_e;

endpackage

// ===== src/bounded_stack_with_delete.sv =====
// Bounded LIFO stack of signed words with push, pop, peek and delete-by-value.
//
// One request at a time. Entries live in a single memory with one write and one
// registered read per cycle, so every step moves at most one entry. Delete reads
// down from the top, one entry per cycle, until it finds a match, then moves
// each entry above the match down one place, one per cycle. The result sits in
// an output register, so a request may be taken while the previous result still
// waits on out_stall_i. Entries need no reset.
`include "bounded_stack_with_delete_assert.svh"

module bounded_stack_with_delete
  import bstk_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic signed [DataW-1:0]     operand_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DataW-1:0]     read_value_o,
  output logic [1:0]                  status_o,
  output logic [DepthNowW-1:0]        depth_now_o
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CMP   = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [AddrW-1:0]    idx_q, idx_d;
  action_e             action_q;
  logic [DataW-1:0]    operand_q;
  logic [DataW-1:0]    res_value_q, res_value_d;
  status_e             res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [DataW-1:0]    out_value_q;
  status_e             out_status_q;
  logic [DepthNowW-1:0] out_depth_q;
  logic [CntW+DepthNowW-1:0] cnt_ext;

  logic [DataW-1:0]    stack_mem [DEPTH];
  logic [DataW-1:0]    rd_data_q;
  logic                mem_we, mem_re;
  logic [AddrW-1:0]    mem_waddr, mem_raddr;
  logic [DataW-1:0]    mem_wdata;

  logic                in_acc;
  logic                out_free;
  logic [AddrW-1:0]    top_idx;
  logic                is_full, is_empty;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign top_idx    = AddrW'(cnt_q - 1'b1);
  assign is_full    = (cnt_q == CntW'(DEPTH));
  assign is_empty   = (cnt_q == '0);
  assign cnt_ext    = {{DepthNowW{1'b0}}, cnt_q};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = rd_data_q;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;

    // Drain the output register when the consumer takes the result.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_value_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_DONE;
          unique case (action_e'(action_i))
            ACT_PUSH: begin
              if (is_full) begin
                res_status_d = ST_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AddrW'(cnt_q);
                mem_wdata = operand_i;
                cnt_d     = cnt_q + 1'b1;
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (is_empty) begin
                res_status_d = ST_UNDERFLOW;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = top_idx;
                state_d   = S_READ;
              end
            end
            ACT_DELETE: begin
              if (is_empty) begin
                res_status_d = ST_UNDERFLOW;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = top_idx;
                idx_d     = top_idx;
                state_d   = S_CMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_value_d = rd_data_q;
        if (action_q == ACT_POP) begin
          cnt_d = cnt_q - 1'b1;
        end
        state_d = S_DONE;
      end
      S_CMP: begin
        if (rd_data_q == operand_q) begin
          if (idx_q == top_idx) begin
            cnt_d   = cnt_q - 1'b1;
            state_d = S_DONE;
          end else begin
            // Start moving the entries above the match down.
            mem_re    = 1'b1;
            mem_raddr = idx_q + 1'b1;
            idx_d     = idx_q + 1'b1;
            state_d   = S_SHIFT;
          end
        end else if (idx_q == '0) begin
          res_status_d = ST_NOTFOUND;
          state_d      = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q - 1'b1;
          idx_d     = idx_q - 1'b1;
        end
      end
      S_SHIFT: begin
        // Read one above while writing the previous entry one below.
        mem_we    = 1'b1;
        mem_waddr = idx_q - 1'b1;
        mem_wdata = rd_data_q;
        if (idx_q == top_idx) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    if (in_acc) begin
      action_q  <= action_e'(action_i);
      operand_q <= operand_i;
    end
    if (out_load) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
      out_depth_q  <= cnt_ext[DepthNowW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= stack_mem[mem_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;
  assign depth_now_o  = out_depth_q;

  `BSTK_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(DEPTH), "stack count beyond depth")
  `BSTK_ASSERT_NOW(a_mem_write_src, mem_we,
                   (state_q == S_SHIFT) || (in_acc && action_i == ACT_PUSH),
                   "unexpected memory write")
  `BSTK_ASSERT_NEXT(a_idle_cnt_hold, (state_q == S_IDLE) && !in_acc, $stable(cnt_q),
                    "count changed without a request")
  `BSTK_ASSERT_NOW(a_out_from_done, $rose(out_valid_q), $past(state_q) == S_DONE,
                   "result presented without a finished request")

endmodule
